// ----- hdl/dtbed_pkg.sv -----
package dtbed_pkg;

	localparam int STAGES    = 4;
	localparam int FILTERS   = 2;
	localparam int WINDOW    = 32;
	localparam int FRAC_BITS = 12;

	localparam int DW      = 32;
	localparam int MCW     = $clog2(DW);
	localparam int SEC_TOT = STAGES * FILTERS;
	localparam int SW      = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int FW      = (FILTERS > 1) ? $clog2(FILTERS) : 1;
	localparam int PW      = $clog2(WINDOW);
	localparam int RAM_D   = FILTERS * WINDOW;
	localparam int AW      = $clog2(RAM_D);

	localparam int SAMPLE_W = 12;
	localparam int ENV_W    = 31;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 64;

	localparam logic [ENV_W-1:0] THR_RESET = ENV_W'(1024);

	typedef enum logic [1:0] {
		COEF_A1,
		COEF_A2,
		COEF_GAIN
	} coef_sel_t;

	// Magnitudes scaled by 2^16: |a1|, a2, gain for two filters of four sections.
	localparam logic [16:0] COEF_Q16 [2][4][3] = '{
		'{ '{17'd121191, 17'd65163, 17'd479}, '{17'd121854, 17'd65175, 17'd479},
		   '{17'd120908, 17'd64647, 17'd477}, '{17'd121188, 17'd64660, 17'd477} },
		'{ '{17'd116508, 17'd65080, 17'd585}, '{17'd117483, 17'd65095, 17'd585},
		   '{17'd116234, 17'd64452, 17'd582}, '{17'd116644, 17'd64466, 17'd582} }
	};

	function automatic logic [DW-1:0] coef_word(input logic row, input logic [1:0] ent,
			input coef_sel_t sel);
		logic [16:0]   q;
		logic [DW-1:0] v;
		unique case (sel)
			COEF_A1:   q = COEF_Q16[row][ent][0];
			COEF_A2:   q = COEF_Q16[row][ent][1];
			COEF_GAIN: q = COEF_Q16[row][ent][2];
			default:   q = '0;
		endcase
		v = DW'(q) >> (16 - FRAC_BITS);
		if (sel == COEF_A1) begin
			v = DW'(0) - v;
		end
		return v;
	endfunction

	function automatic logic [DW-1:0] asr(input logic [DW-1:0] v);
		return DW'($signed(v) >>> FRAC_BITS);
	endfunction

endpackage

// ----- hdl/dual_tone_biquad_envelope_detector_top.sv -----
// Dual-tone detector: each 12-bit sample runs through two bandpass filters of four
// biquad sections, and each filter's largest output over the last 32 samples,
// floored at zero, is reported with a flag that says whether it exceeds the
// threshold. Each section runs a start step and then three bit-serial multiplies on
// the single shared multiplier. Each filter then hands off its result, writes it into
// the window, and scans its window one RAM entry per cycle. A new item is taken once
// the previous result has moved to the output register, and a stalled output holds
// back the next item.
module dual_tone_biquad_envelope_detector_top
	import dtbed_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // sample[11:0], zero fill above
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // tone_low_present, tone_high_present,
	                                    // envelope_low[30:0], envelope_high[30:0]
	input  logic             cfg_we,
	input  logic [ENV_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT,
		ST_WRITE,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [ENV_W-1:0]    thr_q;
	logic [DW-1:0]       x_q, y_q;
	logic [FW-1:0]       f_q;
	logic [PW-1:0]       ptr_q;
	logic [PW:0]         scan_q;
	logic [PW-1:0]       rd_idx_s1;
	logic                rd_vld_s1;
	logic [WINDOW-1:0]   wvld_q;
	logic signed [DW-1:0] best_q;
	logic [ENV_W-1:0]    env_q [FILTERS];
	logic                start_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                bq_done;
	logic [DW-1:0]       bq_y;
	logic                ram_we;
	logic [AW-1:0]       base, waddr, raddr;
	logic [DW-1:0]       rdata;
	logic signed [DW-1:0] best_nx;
	logic [ENV_W-1:0]    env_lo, env_hi;

	dtbed_biquad u_biquad (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.x_in   (x_q),
		.done   (bq_done),
		.y      (bq_y)
	);

	assign base   = AW'(f_q) * AW'(WINDOW);
	assign waddr  = base + AW'(ptr_q);
	assign raddr  = base + AW'(scan_q[PW-1:0]);
	assign ram_we = (state_q == ST_WRITE);

	dtbed_ram #(
		.WIDTH (DW),
		.DEPTH (RAM_D)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (y_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Slots never written since reset count as zero, which the zero floor absorbs.
	always_comb begin
		best_nx = best_q;
		if (rd_vld_s1 && wvld_q[rd_idx_s1] && ($signed(rdata) > best_q)) begin
			best_nx = $signed(rdata);
		end
	end

	assign env_lo = env_q[0];
	generate
		if (FILTERS > 1) begin : g_hi
			assign env_hi = env_q[1];
		end else begin : g_no_hi
			assign env_hi = '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= '0;
			y_q        <= '0;
			f_q        <= '0;
			ptr_q      <= '0;
			scan_q     <= '0;
			rd_idx_s1  <= '0;
			rd_vld_s1  <= 1'b0;
			wvld_q     <= '0;
			best_q     <= '0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			for (int i = 0; i < FILTERS; i++) begin
				env_q[i] <= '0;
			end
		end else begin
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= DW'(s_tdata[SAMPLE_W-1:0]);
						f_q     <= '0;
						start_q <= 1'b1;
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (bq_done) begin
						y_q     <= bq_y;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					wvld_q[ptr_q] <= 1'b1;
					scan_q        <= '0;
					rd_vld_s1     <= 1'b0;
					best_q        <= '0;
					state_q       <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_vld_s1 <= (scan_q < (PW+1)'(WINDOW));
					rd_idx_s1 <= scan_q[PW-1:0];
					if (scan_q < (PW+1)'(WINDOW)) begin
						scan_q <= scan_q + 1'b1;
					end
					best_q <= best_nx;
					if (rd_vld_s1 && rd_idx_s1 == PW'(WINDOW - 1)) begin
						env_q[f_q] <= best_nx[ENV_W-1:0];
						if (f_q == FW'(FILTERS - 1)) begin
							ptr_q   <= (ptr_q == PW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
							state_q <= ST_OUT;
						end else begin
							f_q     <= f_q + 1'b1;
							start_q <= 1'b1;
							state_q <= ST_FILT;
						end
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {env_hi, env_lo,
							(FILTERS > 1) && (env_hi > thr_q), env_lo > thr_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_done_in_filt: assert property (@(posedge clk) disable iff (!arst_n)
		bq_done |-> state_q == ST_FILT)
		else $error("filter result arrived outside the filter phase");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PW'(WINDOW - 1))
		else $error("window pointer beyond the window");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> start_q && state_q == ST_FILT)
		else $error("accepted item did not start the filters");
`endif

endmodule

// ----- hdl/dtbed_ram.sv -----
module dtbed_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/dtbed_smul.sv -----
module dtbed_smul
	import dtbed_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [DW-1:0] prod
);

	logic [DW-1:0]  a_q, b_q, p_q;
	logic [MCW-1:0] cnt_q;
	logic           busy_q, done_q;

	// One multiplier bit per cycle; the product wraps at the word width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q    <= a;
				b_q    <= b;
				p_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) begin
					p_q <= p_q + a_q;
				end
				a_q   <= {a_q[DW-2:0], 1'b0};
				b_q   <= {1'b0, b_q[DW-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MCW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

// ----- hdl/dtbed_biquad.sv -----
module dtbed_biquad
	import dtbed_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] x_in,
	output logic          done,
	output logic [DW-1:0] y
);

	typedef enum logic [2:0] {
		BQ_IDLE,
		BQ_L0,
		BQ_M0,
		BQ_M1,
		BQ_M2
	} bq_state_t;

	bq_state_t     state_q;
	logic [DW-1:0] x_q, sum_q, w_q, y_q;
	logic [SW-1:0] s_q;
	logic [FW-1:0] f_q;
	logic          done_q;

	// Delay words of all sections as a rotating line; the head is the active section.
	logic [DW-1:0] dl0_q [SEC_TOT];
	logic [DW-1:0] dl1_q [SEC_TOT];

	logic          mul_go, mul_done;
	logic [DW-1:0] mul_a, mul_b, prod;
	logic [3:0]    s_ext, f_ext;
	logic [DW-1:0] c_a1, c_a2, c_gain, w_val, t_val;

	assign s_ext  = 4'(s_q);
	assign f_ext  = 4'(f_q);
	assign c_a1   = coef_word(f_ext[0], s_ext[1:0], COEF_A1);
	assign c_a2   = coef_word(f_ext[0], s_ext[1:0], COEF_A2);
	assign c_gain = coef_word(f_ext[0], s_ext[1:0], COEF_GAIN);
	assign w_val  = asr(sum_q - prod);
	assign t_val  = asr((w_val - dl1_q[0]) << FRAC_BITS);

	always_comb begin
		mul_go = 1'b0;
		mul_a  = dl0_q[0];
		mul_b  = c_a1;
		case (state_q)
			BQ_L0: begin
				mul_go = 1'b1;
			end
			BQ_M0: begin
				mul_go = mul_done;
				mul_a  = dl1_q[0];
				mul_b  = c_a2;
			end
			BQ_M1: begin
				mul_go = mul_done;
				mul_a  = t_val;
				mul_b  = c_gain;
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	dtbed_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BQ_IDLE;
			x_q     <= '0;
			sum_q   <= '0;
			w_q     <= '0;
			y_q     <= '0;
			s_q     <= '0;
			f_q     <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < SEC_TOT; i++) begin
				dl0_q[i] <= '0;
				dl1_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				BQ_IDLE: begin
					if (start) begin
						x_q     <= x_in;
						state_q <= BQ_L0;
					end
				end
				BQ_L0: begin
					state_q <= BQ_M0;
				end
				BQ_M0: begin
					if (mul_done) begin
						sum_q   <= (x_q << FRAC_BITS) - prod;
						state_q <= BQ_M1;
					end
				end
				BQ_M1: begin
					if (mul_done) begin
						w_q     <= w_val;
						state_q <= BQ_M2;
					end
				end
				BQ_M2: begin
					if (mul_done) begin
						for (int i = 0; i < SEC_TOT - 1; i++) begin
							dl0_q[i] <= dl0_q[i+1];
							dl1_q[i] <= dl1_q[i+1];
						end
						dl0_q[SEC_TOT-1] <= w_q;
						dl1_q[SEC_TOT-1] <= dl0_q[0];
						if (s_q == SW'(STAGES - 1)) begin
							s_q     <= '0;
							f_q     <= (f_q == FW'(FILTERS - 1)) ? '0 : f_q + 1'b1;
							y_q     <= asr(prod);
							done_q  <= 1'b1;
							state_q <= BQ_IDLE;
						end else begin
							s_q     <= s_q + 1'b1;
							x_q     <= asr(prod);
							state_q <= BQ_L0;
						end
					end
				end
				default: begin
					state_q <= BQ_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule
